>>> rtl/dptbd_pkg.sv
// Package for the dual pilot tone bias driver: sizes, codes, transaction
// structs, the quarter-wave sine table and the tone/saturation helpers.
// No dependencies.
package dptbd_pkg;

  // Sizes
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int CODE_BITS      = 16;
  localparam int FRAC_BITS      = SINE_ADDR_BITS - 2;
  localparam int LUT_DEPTH      = 1 << FRAC_BITS;
  localparam int MAG_W          = 15;
  localparam int TONE_W         = 17;
  localparam int SUM_W          = (CODE_BITS + 1 > TONE_W + 1) ? CODE_BITS + 1 : TONE_W + 1;
  localparam int CFG_ADDR_W     = 5;
  localparam int CFG_DATA_W     = 32;

  // Taylor coefficients of sin(pi/2 * x), Q2.30
  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598669;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172272;

  // Saturation bounds of the DAC code range
  localparam logic signed [SUM_W-1:0] CODE_HI = SUM_W'((1 << (CODE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] CODE_LO = SUM_W'(-(1 << (CODE_BITS - 1)));

  typedef enum logic [1:0] {
    REQ_TICK       = 2'd0,
    REQ_SET_BIAS   = 2'd1,
    REQ_SCAN_BEGIN = 2'd2,
    REQ_SCAN_END   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    REG_I_PHASE_STEP      = 3'd0,
    REG_Q_PHASE_STEP      = 3'd1,
    REG_I_TONE_AMPLITUDE  = 3'd2,
    REG_Q_TONE_AMPLITUDE  = 3'd3,
    REG_CONTINUOUS_ENABLE = 3'd4,
    REG_ONBOARD_SOURCE    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] new_bias_i;
    logic signed [15:0] new_bias_q;
    logic signed [15:0] new_bias_p;
    logic               pilot_req;
  } in_item_t;

  typedef struct packed {
    logic               write_iq;
    logic               write_p;
    logic signed [15:0] drive_i;
    logic signed [15:0] drive_q;
    logic signed [15:0] drive_p;
  } out_item_t;

  typedef logic [LUT_DEPTH-1:0][MAG_W-1:0] sine_lut_t;

  // Fixed-point sine magnitude for quarter-wave offset r (0 .. LUT_DEPTH),
  // Horner form with each polynomial product truncated by 30 bits and the final scaling rounded. Elaboration only.
  function automatic logic [MAG_W-1:0] sine_mag_calc(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    x   = 64'(r) << (30 - FRAC_BITS);
    x2  = (x * x) >> 30;
    t   = K7 - ((x2 * K9) >> 30);
    t   = K5 - ((x2 * t) >> 30);
    t   = K3 - ((x2 * t) >> 30);
    t   = K1 - ((x2 * t) >> 30);
    s   = (x * t) >> 30;
    mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return MAG_W'(mag);
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      lut[k] = sine_mag_calc(k);
    end
    return lut;
  endfunction

  localparam sine_lut_t        SINE_LUT  = build_sine_lut();
  // Quarter-wave peak, reached only by mirroring offset zero in odd quadrants
  localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag_calc(LUT_DEPTH);

  // Signed tone: amplitude times sine of phase, magnitude rounded half up
  function automatic logic signed [TONE_W-1:0] tone(input logic [MAG_W-1:0] amp,
                                                    input logic [PHASE_BITS-1:0] ph);
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [1:0]                quad;
    logic [FRAC_BITS:0]        r;
    logic [MAG_W-1:0]          mag;
    logic [2*MAG_W:0]          prod;
    logic signed [TONE_W-1:0]  tmag;
    addr = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
    quad = addr[SINE_ADDR_BITS-1 -: 2];
    r    = {1'b0, addr[FRAC_BITS-1:0]};
    if (quad[0]) begin
      r = (FRAC_BITS + 1)'(LUT_DEPTH) - r;
    end
    if (r[FRAC_BITS]) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_LUT[r[FRAC_BITS-1:0]];
    end
    prod = (2*MAG_W + 1)'(amp) * (2*MAG_W + 1)'(mag) + (2*MAG_W + 1)'(16384);
    tmag = $signed({1'b0, prod[2*MAG_W -: TONE_W-1]});
    return quad[1] ? -tmag : tmag;
  endfunction

  // Clamp to the signed DAC code range, carried in a 16-bit field
  function automatic logic signed [15:0] sat_code(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > CODE_HI) begin
      c = CODE_HI;
    end else if (v < CODE_LO) begin
      c = CODE_LO;
    end else begin
      c = v;
    end
    return c[15:0];
  endfunction

endpackage

>>> rtl/dual_pilot_tone_bias_driver.sv
// Top level of the dual pilot tone bias driver: input register, result
// logic, result register, bias/phase state and the APB register file.
// Depends on dptbd_pkg.
//
//  channel  direction  handshake                  payload
//  in       in         in_valid_i / in_stall_o    dptbd_pkg::in_item_t
//  out      out        out_valid_o / out_stall_i  dptbd_pkg::out_item_t
//  cfg      in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction per cycle sustained while the result is not stalled; a request
// is held in the input register and its result in the result register, the path
// being sine table lookup, one 15x15 multiply and the saturating add per I/Q
// channel, between input and result registers.
// Reset clears biases, phases, scan state and the registers (onboard source
// resets to 1). A stalled result holds; the input stage keeps taking items
// until its register is full behind a stalled result.
module dual_pilot_tone_bias_driver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  dptbd_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output dptbd_pkg::out_item_t               out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dptbd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [dptbd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [dptbd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready
);

  // Configuration registers
  logic [31:0]                 i_step_q, q_step_q;
  logic [dptbd_pkg::MAG_W-1:0] i_amp_q, q_amp_q;
  logic                        cont_en_q, onboard_q;
  logic                        cfg_wr;
  dptbd_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dptbd_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_step_q  <= '0;
      q_step_q  <= '0;
      i_amp_q   <= '0;
      q_amp_q   <= '0;
      cont_en_q <= 1'b0;
      onboard_q <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dptbd_pkg::REG_I_PHASE_STEP:      i_step_q  <= pwdata;
        dptbd_pkg::REG_Q_PHASE_STEP:      q_step_q  <= pwdata;
        dptbd_pkg::REG_I_TONE_AMPLITUDE:  i_amp_q   <= pwdata[dptbd_pkg::MAG_W-1:0];
        dptbd_pkg::REG_Q_TONE_AMPLITUDE:  q_amp_q   <= pwdata[dptbd_pkg::MAG_W-1:0];
        dptbd_pkg::REG_CONTINUOUS_ENABLE: cont_en_q <= pwdata[0];
        dptbd_pkg::REG_ONBOARD_SOURCE:    onboard_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      dptbd_pkg::REG_I_PHASE_STEP:      prdata = i_step_q;
      dptbd_pkg::REG_Q_PHASE_STEP:      prdata = q_step_q;
      dptbd_pkg::REG_I_TONE_AMPLITUDE:  prdata = 32'(i_amp_q);
      dptbd_pkg::REG_Q_TONE_AMPLITUDE:  prdata = 32'(q_amp_q);
      dptbd_pkg::REG_CONTINUOUS_ENABLE: prdata = 32'(cont_en_q);
      dptbd_pkg::REG_ONBOARD_SOURCE:    prdata = 32'(onboard_q);
      default:                          prdata = '0;
    endcase
  end

  // Pipeline registers and state
  logic                               s1_valid_q;
  dptbd_pkg::in_item_t                s1_data_q;
  logic                               out_valid_q;
  dptbd_pkg::out_item_t               out_data_q;
  logic signed [15:0]                 bias_i_q, bias_q_q, bias_p_q;
  logic signed [15:0]                 bias_i_d, bias_q_d, bias_p_d;
  logic [dptbd_pkg::PHASE_BITS-1:0]   i_phase_q, q_phase_q, i_phase_d, q_phase_d;
  logic                               scan_q, scan_d;
  logic                               s1_adv;
  logic                               pilot_active;
  logic                               res_valid;
  logic                               with_tone;
  dptbd_pkg::out_item_t               res;
  dptbd_pkg::req_type_e               req;
  logic signed [dptbd_pkg::TONE_W-1:0] tone_i, tone_q;

  assign s1_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign req          = dptbd_pkg::req_type_e'(s1_data_q.req_type);
  assign pilot_active = onboard_q && (cont_en_q || scan_q);
  assign tone_i       = dptbd_pkg::tone(i_amp_q, i_phase_q);
  assign tone_q       = dptbd_pkg::tone(q_amp_q, q_phase_q);

  // Request decode: next state and result fields
  always_comb begin
    bias_i_d     = bias_i_q;
    bias_q_d     = bias_q_q;
    bias_p_d     = bias_p_q;
    i_phase_d    = i_phase_q;
    q_phase_d    = q_phase_q;
    scan_d       = scan_q;
    res_valid    = 1'b1;
    with_tone    = 1'b0;
    res.write_iq = 1'b1;
    res.write_p  = 1'b1;
    case (req)
      dptbd_pkg::REQ_TICK: begin
        res_valid   = pilot_active;
        with_tone   = 1'b1;
        res.write_p = 1'b0;
        if (pilot_active) begin
          i_phase_d = i_phase_q + dptbd_pkg::PHASE_BITS'(i_step_q);
          q_phase_d = q_phase_q + dptbd_pkg::PHASE_BITS'(q_step_q);
        end
      end
      dptbd_pkg::REQ_SET_BIAS: begin
        bias_i_d  = s1_data_q.new_bias_i;
        bias_q_d  = s1_data_q.new_bias_q;
        bias_p_d  = s1_data_q.new_bias_p;
        with_tone = scan_q && onboard_q;
      end
      dptbd_pkg::REQ_SCAN_BEGIN: begin
        i_phase_d = '0;
        q_phase_d = '0;
        // tone at cleared phase is zero, so raw biases suffice
        if (s1_data_q.pilot_req && onboard_q) begin
          scan_d      = 1'b1;
          res.write_p = 1'b0;
        end else begin
          scan_d = 1'b0;
        end
      end
      default: begin
        scan_d    = 1'b0;
        i_phase_d = '0;
        q_phase_d = '0;
      end
    endcase
    if (with_tone) begin
      res.drive_i = dptbd_pkg::sat_code(dptbd_pkg::SUM_W'(bias_i_d)
                                        + dptbd_pkg::SUM_W'(tone_i));
      res.drive_q = dptbd_pkg::sat_code(dptbd_pkg::SUM_W'(bias_q_d)
                                        + dptbd_pkg::SUM_W'(tone_q));
    end else begin
      res.drive_i = dptbd_pkg::sat_code(dptbd_pkg::SUM_W'(bias_i_d));
      res.drive_q = dptbd_pkg::sat_code(dptbd_pkg::SUM_W'(bias_q_d));
    end
    res.drive_p = dptbd_pkg::sat_code(dptbd_pkg::SUM_W'(bias_p_d));
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bias_i_q    <= '0;
      bias_q_q    <= '0;
      bias_p_q    <= '0;
      i_phase_q   <= '0;
      q_phase_q   <= '0;
      scan_q      <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && res_valid;
      end
      if (s1_valid_q && s1_adv) begin
        bias_i_q  <= bias_i_d;
        bias_q_q  <= bias_q_d;
        bias_p_q  <= bias_p_d;
        i_phase_q <= i_phase_d;
        q_phase_q <= q_phase_d;
        scan_q    <= scan_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // A tick with the pilot off produces no result
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv && (req == dptbd_pkg::REQ_TICK) && !pilot_active
    |=> !out_valid_q)
    else $error("result produced by inactive tick");

  // Scan begin and end restart both oscillators
  a_phase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv
    && ((req == dptbd_pkg::REQ_SCAN_BEGIN) || (req == dptbd_pkg::REQ_SCAN_END))
    |=> (i_phase_q == '0) && (q_phase_q == '0))
    else $error("phase not cleared by scan request");

  // Input is held off only when the input stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free input stage");

  // Active tick advances the I phase by its step
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv && (req == dptbd_pkg::REQ_TICK) && pilot_active
    |=> i_phase_q == $past(i_phase_q + dptbd_pkg::PHASE_BITS'(i_step_q)))
    else $error("I phase did not advance on tick");
`endif

endmodule

>>> dv/dual_pilot_tone_bias_driver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_pilot_tone_bias_driver: directed table, then
// random scan sequences under several register settings. Depends on dptbd_pkg.
module dual_pilot_tone_bias_driver_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 48;
  localparam int PHASE_ITEMS   = 95;
  localparam int RANDOM_ITEMS  = 760;

  // Sine polynomial coefficients, Q2.30 (odd powers up to nine)
  localparam longint unsigned TAY_C1 = 64'd1686629713;
  localparam longint unsigned TAY_C3 = 64'd693598669;
  localparam longint unsigned TAY_C5 = 64'd85569306;
  localparam longint unsigned TAY_C7 = 64'd5026995;
  localparam longint unsigned TAY_C9 = 64'd172272;

  typedef struct packed {
    logic [31:0] i_step;
    logic [31:0] q_step;
    logic [14:0] i_amp;
    logic [14:0] q_amp;
    logic        cont;
    logic        onb;
  } tone_settings_t;

  typedef struct {
    bit                   is_cfg;
    tone_settings_t       cfg;
    dptbd_pkg::in_item_t  item;
    bit                   typed;
    bit                   has_res;
    dptbd_pkg::out_item_t res;
  } dir_row_t;

  // DUT ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  dptbd_pkg::in_item_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  dptbd_pkg::out_item_t out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [dptbd_pkg::CFG_ADDR_W-1:0] paddr  = '0;
  logic [dptbd_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [dptbd_pkg::CFG_DATA_W-1:0] prdata;
  logic                 pready;

  // Side info travelling with the current transaction
  bit                   row_typed   = 1'b0;
  bit                   row_has_res = 1'b0;
  dptbd_pkg::out_item_t row_exp     = '0;

  // Predictor state and register copy
  tone_settings_t     cfg       = '{32'd0, 32'd0, 15'd0, 15'd0, 1'b0, 1'b1};
  logic signed [15:0] bias_i    = '0;
  logic signed [15:0] bias_q    = '0;
  logic signed [15:0] bias_p    = '0;
  logic [31:0]        i_phase   = '0;
  logic [31:0]        q_phase   = '0;
  bit                 scanning  = 1'b0;

  dptbd_pkg::out_item_t expected_drives[$];
  dir_row_t             directed_rows[$];

  // Run bookkeeping
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  int failures  = 0;
  int items_sent = 0;
  int applied_items = 0;
  int ignored_ticks = 0;
  int results_checked = 0;
  int settings_written = 0;
  int long_holds = 0;
  int backpressure_cycles = 0;

  dual_pilot_tone_bias_driver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("dual_pilot_tone_bias_driver_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Signed sine sample in codes of 1/32767 for the top ten phase bits
  function automatic longint sine_code(input logic [31:0] ph);
    logic [9:0]      a;
    longint unsigned r, x, x2, t, s, m;
    a = ph[31:22];
    r = a[7:0];
    if (a[8]) begin
      r = 256 - r;
    end
    x  = r << 22;
    x2 = (x * x) >> 30;
    t  = TAY_C7 - ((x2 * TAY_C9) >> 30);
    t  = TAY_C5 - ((x2 * t) >> 30);
    t  = TAY_C3 - ((x2 * t) >> 30);
    t  = TAY_C1 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    m  = (s * 32767 + (64'd1 << 29)) >> 30;
    if (m > 32767) begin
      m = 32767;
    end
    return a[9] ? -longint'(m) : longint'(m);
  endfunction

  // Amplitude times sine, magnitude rounded half up, symmetric about zero
  function automatic longint tone_offset(input logic [14:0] amp, input logic [31:0] ph);
    longint s, m;
    s = sine_code(ph);
    m = (longint'(amp) * (s < 0 ? -s : s) + 16384) >> 15;
    return s < 0 ? -m : m;
  endfunction

  function automatic logic signed [15:0] clamp_code(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic dptbd_pkg::out_item_t drive_codes(input bit wiq, input bit wp,
                                                       input bit with_tone);
    dptbd_pkg::out_item_t o;
    longint               di, dq;
    di = bias_i;
    dq = bias_q;
    if (with_tone) begin
      di += tone_offset(cfg.i_amp, i_phase);
      dq += tone_offset(cfg.q_amp, q_phase);
    end
    o.write_iq = wiq;
    o.write_p  = wp;
    o.drive_i  = clamp_code(di);
    o.drive_q  = clamp_code(dq);
    o.drive_p  = bias_p;
    return o;
  endfunction

  // Applies one request to the predictor; returns 1 when a result is due
  function automatic bit apply_request(input dptbd_pkg::in_item_t it,
                                       output dptbd_pkg::out_item_t r);
    r = '0;
    case (it.req_type)
      dptbd_pkg::REQ_TICK: begin
        if (!(cfg.onb && (cfg.cont || scanning))) begin
          return 1'b0;
        end
        r = drive_codes(1'b1, 1'b0, 1'b1);
        i_phase += cfg.i_step;
        q_phase += cfg.q_step;
      end
      dptbd_pkg::REQ_SET_BIAS: begin
        bias_i = it.new_bias_i;
        bias_q = it.new_bias_q;
        bias_p = it.new_bias_p;
        r = drive_codes(1'b1, 1'b1, scanning && cfg.onb);
      end
      dptbd_pkg::REQ_SCAN_BEGIN: begin
        i_phase = '0;
        q_phase = '0;
        if (it.pilot_req && cfg.onb) begin
          scanning = 1'b1;
          r = drive_codes(1'b1, 1'b0, 1'b1);
        end else begin
          scanning = 1'b0;
          r = drive_codes(1'b1, 1'b1, 1'b0);
        end
      end
      default: begin
        scanning = 1'b0;
        i_phase  = '0;
        q_phase  = '0;
        r = drive_codes(1'b1, 1'b1, 1'b0);
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transactions, check output transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    dptbd_pkg::out_item_t pred;
    dptbd_pkg::out_item_t e;
    bit                   due;
    string                exp_s, got_s;
    if (rst_ni && in_valid_i && in_stall_o) begin
      backpressure_cycles++;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      due = apply_request(in_data_i, pred);
      if (due) begin
        applied_items++;
      end else begin
        ignored_ticks++;
      end
      if (row_typed) begin
        if (row_has_res) begin
          expected_drives.push_back(row_exp);
        end
      end else if (due) begin
        expected_drives.push_back(pred);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_s = $sformatf("wiq=%0b wp=%0b i=%0d q=%0d p=%0d",
                        out_data_o.write_iq, out_data_o.write_p, out_data_o.drive_i,
                        out_data_o.drive_q, out_data_o.drive_p);
      if (expected_drives.size() == 0) begin
        note_failure($sformatf("result with none pending: %s", got_s));
      end else begin
        e = expected_drives.pop_front();
        results_checked++;
        if (out_data_o.write_iq !== e.write_iq || out_data_o.write_p !== e.write_p ||
            out_data_o.drive_i !== e.drive_i || out_data_o.drive_q !== e.drive_q ||
            out_data_o.drive_p !== e.drive_p) begin
          exp_s = $sformatf("wiq=%0b wp=%0b i=%0d q=%0d p=%0d", e.write_iq, e.write_p,
                            e.drive_i, e.drive_q, e.drive_p);
          note_failure($sformatf("result %0d: exp %s, got %s",
                                 results_checked, exp_s, got_s));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold on request
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  initial begin : receiver
    int remaining;
    remaining = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        remaining = HOLD_CYCLES;
        long_holds++;
      end else if (remaining == 0 && rst_ni) begin
        remaining = pick_gap();
      end
      if (remaining > 0) begin
        out_stall_i <= 1'b1;
        remaining--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side and register access
  // ---------------------------------------------------------------------------
  task automatic offer(input dptbd_pkg::in_item_t it, input bit typed, input bit has_res,
                       input dptbd_pkg::out_item_t e);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    in_data_i   <= it;
    row_typed   <= typed;
    row_has_res <= has_res;
    row_exp     <= e;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Let the block drain; ignored ticks may still be in flight after the last result
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input dptbd_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_settings(input tone_settings_t s);
    settle();
    apb_write(dptbd_pkg::REG_I_PHASE_STEP, s.i_step);
    apb_write(dptbd_pkg::REG_Q_PHASE_STEP, s.q_step);
    apb_write(dptbd_pkg::REG_I_TONE_AMPLITUDE, {17'd0, s.i_amp});
    apb_write(dptbd_pkg::REG_Q_TONE_AMPLITUDE, {17'd0, s.q_amp});
    apb_write(dptbd_pkg::REG_CONTINUOUS_ENABLE, {31'd0, s.cont});
    apb_write(dptbd_pkg::REG_ONBOARD_SOURCE, {31'd0, s.onb});
    cfg = s;
    settings_written++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic dptbd_pkg::in_item_t req(input dptbd_pkg::req_type_e rt, input int bi,
                                              input int bq, input int bp,
                                              input bit use_pilot);
    dptbd_pkg::in_item_t it;
    it.req_type   = rt;
    it.new_bias_i = bi[15:0];
    it.new_bias_q = bq[15:0];
    it.new_bias_p = bp[15:0];
    it.pilot_req  = use_pilot;
    return it;
  endfunction

  function automatic dptbd_pkg::out_item_t drv(input bit wiq, input bit wp, input int di,
                                               input int dq, input int dp);
    dptbd_pkg::out_item_t o;
    o.write_iq = wiq;
    o.write_p  = wp;
    o.drive_i  = di[15:0];
    o.drive_q  = dq[15:0];
    o.drive_p  = dp[15:0];
    return o;
  endfunction

  function automatic dir_row_t row_cfg(input tone_settings_t s);
    dir_row_t d;
    d = '{1'b1, s, '0, 1'b0, 1'b0, '0};
    return d;
  endfunction

  // Row checked against the predictor
  function automatic dir_row_t row_pred(input dptbd_pkg::in_item_t it);
    dir_row_t d;
    d = '{1'b0, '0, it, 1'b0, 1'b0, '0};
    return d;
  endfunction

  // Row with a hand-written outcome; has_res 0 means no result at all
  function automatic dir_row_t row_known(input dptbd_pkg::in_item_t it, input bit has_res,
                                         input dptbd_pkg::out_item_t r);
    dir_row_t d;
    d = '{1'b0, '0, it, 1'b1, has_res, r};
    return d;
  endfunction

  function automatic logic signed [15:0] pick_bias();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dptbd_pkg::in_item_t rand_item(input dptbd_pkg::req_type_e rt);
    dptbd_pkg::in_item_t it;
    it.req_type   = rt;
    it.new_bias_i = pick_bias();
    it.new_bias_q = pick_bias();
    it.new_bias_p = pick_bias();
    it.pilot_req  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(1, 1 << 24));
      default: return $urandom;
    endcase
  endfunction

  function automatic tone_settings_t phase_settings(input int p);
    tone_settings_t s;
    s = '{pick_step(), pick_step(), 15'($urandom_range(0, 32767)),
          15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)), 1'b1};
    case (p % 8)
      0: begin
        s.i_amp = 15'h7FFF;
        s.q_amp = 15'h7FFF;
        s.cont  = 1'b0;
      end
      1: begin
        s.i_step = 32'hFFFF_FFFF;
        s.q_step = 32'h0000_0001;
        s.cont   = 1'b1;
      end
      2: begin
        s.i_step = '0;
        s.q_step = '0;
        s.cont   = 1'b1;
        s.onb    = 1'b0;
      end
      3: begin
        s.i_amp = '0;
        s.q_amp = 15'h7FFF;
        s.cont  = 1'b0;
      end
      5: begin
        s.i_step = 32'h8000_0000;
        s.q_step = 32'h4000_0000;
        s.i_amp  = 15'h7FFF;
        s.q_amp  = 15'h7FFF;
        s.cont   = 1'b1;
      end
      6: s.onb = 1'($urandom_range(0, 1));
      7: begin
        s.cont = 1'b0;
        s.onb  = 1'b0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    tone_settings_t      s_quarter, s_ext, s_cont;
    dir_row_t            d;
    dptbd_pkg::in_item_t it;
    int                  goal, phase, phase_start, n_ticks;
    bit                  held;

    s_quarter = '{32'h4000_0000, 32'hC000_0000, 15'h7FFF, 15'h7FFF, 1'b0, 1'b1};
    s_ext     = '{32'hFFFF_FFFF, 32'h0000_0001, 15'h7FFF, 15'h0001, 1'b1, 1'b0};
    s_cont    = '{32'hFFFF_FFFF, 32'h0000_0001, 15'h7FFF, 15'h0001, 1'b1, 1'b1};

    // Reset-state registers: pilot off outside scans, zero amplitude
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b1), 1'b0, '0));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SET_BIAS, 32767, -32768, 0, 1'b0),
                                      1'b1, drv(1'b1, 1'b1, 32767, -32768, 0)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SET_BIAS, -32768, 32767, -1, 1'b1),
                                      1'b1, drv(1'b1, 1'b1, -32768, 32767, -1)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SCAN_BEGIN, 0, 0, 0, 1'b0), 1'b1,
                                      drv(1'b1, 1'b1, -32768, 32767, -1)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b0), 1'b0, '0));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SCAN_BEGIN, 0, 0, 0, 1'b1), 1'b1,
                                      drv(1'b1, 1'b0, -32768, 32767, -1)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b0), 1'b1,
                                      drv(1'b1, 1'b0, -32768, 32767, -1)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SCAN_END, 0, 0, 0, 1'b0), 1'b1,
                                      drv(1'b1, 1'b1, -32768, 32767, -1)));
    // Quarter-turn steps at full amplitude: sine peaks and saturation both ways
    directed_rows.push_back(row_cfg(s_quarter));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SET_BIAS, 32767, -32768, 4660, 1'b0),
                                      1'b1, drv(1'b1, 1'b1, 32767, -32768, 4660)));
    directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_SCAN_BEGIN, 0, 0, 0, 1'b1)));
    repeat (5) directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_SET_BIAS, 0, 0, -32768, 1'b0)));
    directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_SCAN_BEGIN, 0, 0, 0, 1'b1)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SCAN_END, 0, 0, 0, 1'b1), 1'b1,
                                      drv(1'b1, 1'b1, 0, 0, -32768)));
    // External pilot: no tones, scan begin falls back to raw biases
    directed_rows.push_back(row_cfg(s_ext));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b1), 1'b0, '0));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SCAN_BEGIN, 0, 0, 0, 1'b1), 1'b1,
                                      drv(1'b1, 1'b1, 0, 0, -32768)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SET_BIAS, 100, -100, 7, 1'b0), 1'b1,
                                      drv(1'b1, 1'b1, 100, -100, 7)));
    // Continuous pilot outside a scan; a bias write there still goes out raw
    directed_rows.push_back(row_cfg(s_cont));
    directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SET_BIAS, -32768, 32767, 0, 1'b0),
                                      1'b1, drv(1'b1, 1'b1, -32768, 32767, 0)));
    directed_rows.push_back(row_pred(req(dptbd_pkg::REQ_TICK, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row_known(req(dptbd_pkg::REQ_SCAN_END, 0, 0, 0, 1'b0), 1'b1,
                                      drv(1'b1, 1'b1, -32768, 32767, 0)));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (directed_rows[k]) begin
      d = directed_rows[k];
      if (d.is_cfg) begin
        write_settings(d.cfg);
      end else begin
        offer(d.item, d.typed, d.has_res, d.res);
      end
    end

    // Random phases: mostly scan sequences with random content, some noise
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      write_settings(phase_settings(phase));
      quiet       = (phase % 8 == 1) || (phase % 8 == 5);
      phase_start = items_sent;
      held        = 1'b0;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        // Long receiver hold while the sender keeps offering
        if (!held && (phase % 8 == 0 || phase % 8 == 4) &&
            items_sent >= phase_start + 30) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          it = rand_item(dptbd_pkg::REQ_SCAN_BEGIN);
          it.pilot_req = ($urandom_range(0, 9) != 0);
          offer(it, 1'b0, 1'b0, '0);
          n_ticks = $urandom_range(4, 40);
          repeat (n_ticks) begin
            it = rand_item(($urandom_range(0, 99) < 12) ? dptbd_pkg::REQ_SET_BIAS
                                                        : dptbd_pkg::REQ_TICK);
            offer(it, 1'b0, 1'b0, '0);
          end
          if ($urandom_range(0, 99) < 85) begin
            offer(rand_item(dptbd_pkg::REQ_SCAN_END), 1'b0, 1'b0, '0);
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            offer(rand_item(dptbd_pkg::req_type_e'($urandom_range(0, 3))), 1'b0, 1'b0, '0);
          end
        end
      end
      phase++;
    end

    // Drain and wrap up
    quiet = 1'b0;
    settle();
    if (expected_drives.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_drives.size()));
    end
    $display("Summary: %0d items sent, %0d applied, %0d idle ticks, %0d results checked",
             items_sent, applied_items, ignored_ticks, results_checked);
    $display("Summary: %0d settings, %0d long holds, %0d backpressure cycles, %0d failures",
             settings_written, long_holds, backpressure_cycles, failures);
    if (failures == 0) begin
      $display("dual_pilot_tone_bias_driver_tb passed");
    end else begin
      $display("dual_pilot_tone_bias_driver_tb failed");
    end
    $finish;
  end

endmodule

>>> dual_pilot_tone_bias_driver.f
rtl/dptbd_pkg.sv
rtl/dual_pilot_tone_bias_driver.sv
dv/dual_pilot_tone_bias_driver_tb.sv
